// ===== rtl/joint_sample_ema_filter_defines.svh =====
// Assertion helpers shared by the RTL
`ifndef JOINT_SAMPLE_EMA_FILTER_DEFINES_SVH
`define JOINT_SAMPLE_EMA_FILTER_DEFINES_SVH

// same-cycle implication
`define JSEF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JSEF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/jsef_pkg.sv =====
`default_nettype none

package jsef_pkg;

    localparam int CH_W      = 3;
    localparam int RAW_W     = 10;
    localparam int ALPHA_W   = 17;
    localparam int GAIN_W    = 16;
    localparam int DATA_W    = 24;
    localparam int DEG_W     = 8;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;

    // datapath of the shared multiplier
    localparam int ADJ_W  = 11;
    localparam int OP_A_W = 25;
    localparam int OP_B_W = 26;
    localparam int PROD_W = OP_A_W + OP_B_W;
    localparam int ACC_W  = PROD_W + 1;

    localparam int DEF_NUM_JOINTS = 6;
    localparam int JOINT_CHANNELS = 6;

    localparam logic [CH_W-1:0] GRIP_TARGET_CH   = 3'd6;
    localparam logic [CH_W-1:0] GRIP_MEASURED_CH = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_GAIN = 2'd2;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET         = 17'd13107;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE           = 17'h10000;
    localparam logic [GAIN_W-1:0]  POSITION_GAIN_RESET = 16'd256;
    localparam logic [GAIN_W-1:0]  VELOCITY_GAIN_RESET = 16'd2560;

    localparam logic [DEG_W-1:0] GRIP_RESET_DEG = 8'd90;
    localparam logic [RAW_W-1:0] GRIP_RESET_RAW = 10'd90;
    localparam int               GRIP_FULL_SCALE = 1023;

    // 300 deg / 1023 counts in radians, Q0.32
    localparam logic signed [OP_B_W-1:0] ANGLE_SCALE = 26'sd21982792;

    localparam logic signed [ADJ_W-1:0] OFFSET_CENTER   = 11'sd512;
    localparam logic signed [ADJ_W-1:0] OFFSET_SHOULDER = 11'sd870;
    localparam logic signed [ADJ_W-1:0] OFFSET_ELBOW    = 11'sd820;

    localparam int S24_MAX = 8388607;
    localparam int S24_MIN = -8388608;

endpackage

`default_nettype wire

// ===== rtl/joint_sample_ema_filter.sv =====
`default_nettype none

// Joint sample filter. Takes one potentiometer count per transaction and returns one result.
// Joint channels (below NUM_JOINTS) run through a sequencer around a single 25x26 signed
// multiplier that forms seven products in turn (angle scale, two filter terms, position gain,
// velocity gain, two filter terms); a joint result passes through S_ANG_MUL to S_V_RND and
// S_FINISH before it is loaded into the output register, with no new transaction taken
// meanwhile. A gripper channel passes through S_GRIP and S_FINISH, an unused joint channel
// through S_FINISH alone. A finished result waits while the previous one is still stalled at
// the output, which adds those stall cycles. A new transaction is taken in the cycle after
// the result is loaded, even while it is still stalled at the output. Configuration writes
// are taken at any time but are meant for idle periods; a filter weight above 1.0 acts as 1.0.

`include "joint_sample_ema_filter_defines.svh"

module joint_sample_ema_filter
    import jsef_pkg::*;
#(
    parameter int NUM_JOINTS = DEF_NUM_JOINTS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]            cfg_data,

    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [CH_W-1:0]             channel,
    input  wire logic [RAW_W-1:0]            raw_sample,

    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [CH_W-1:0]                  out_channel,
    output logic signed [DATA_W-1:0]         position,
    output logic signed [DATA_W-1:0]         velocity
);

    localparam logic [CH_W-1:0] JOINT_LIMIT = CH_W'(NUM_JOINTS);

    typedef enum logic [4:0] {
        S_IDLE,
        S_ANG_MUL,
        S_ANG_RND,
        S_P_MUL1,
        S_P_MUL2,
        S_P_SUM,
        S_P_RND,
        S_POS_MUL,
        S_POS_RND,
        S_DIFF,
        S_DV_MUL,
        S_DV_RND,
        S_V_MUL1,
        S_V_MUL2,
        S_V_SUM,
        S_V_RND,
        S_GRIP,
        S_FINISH
    } state_t;

    // round to nearest, halves away from zero
    function automatic logic signed [ACC_W-1:0] rnd16(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] y;
        y = x + (x[ACC_W-1] ? ACC_W'(32767) : ACC_W'(32768));
        return y >>> 16;
    endfunction

    function automatic logic signed [ACC_W-1:0] rnd8(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] y;
        y = x + (x[ACC_W-1] ? ACC_W'(127) : ACC_W'(128));
        return y >>> 8;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat24(input logic signed [ACC_W-1:0] x);
        logic signed [DATA_W-1:0] y;
        if (x > ACC_W'(S24_MAX))
            y = DATA_W'(S24_MAX);
        else if (x < ACC_W'(S24_MIN))
            y = DATA_W'(S24_MIN);
        else
            y = DATA_W'(x);
        return y;
    endfunction

    function automatic logic signed [ADJ_W-1:0] joint_adjust(
        input logic [CH_W-1:0]  ch,
        input logic [RAW_W-1:0] raw
    );
        logic signed [ADJ_W-1:0] r;
        logic signed [ADJ_W-1:0] adj;
        r = ADJ_W'(raw);
        case (ch)
            3'd0:    adj = r - OFFSET_CENTER;
            3'd1:    adj = OFFSET_SHOULDER - r;
            3'd2:    adj = OFFSET_ELBOW - r;
            3'd3:    adj = OFFSET_CENTER - r;
            3'd4:    adj = OFFSET_CENTER - r;
            3'd5:    adj = r - OFFSET_CENTER;
            default: adj = '0;
        endcase
        return adj;
    endfunction

    // floor(raw*180/1023): quotient estimate by >>10 is short by at most one
    function automatic logic [DEG_W-1:0] grip_degrees(input logic [RAW_W-1:0] raw);
        logic [17:0]      x;
        logic [DEG_W-1:0] q;
        logic [10:0]      r;
        x = (18'(raw) << 7) + (18'(raw) << 5) + (18'(raw) << 4) + (18'(raw) << 2);
        q = x[17:10];
        r = 11'(x[9:0]) + 11'(q);
        if (r >= 11'(GRIP_FULL_SCALE))
            q = q + DEG_W'(1);
        return q;
    endfunction

    state_t state_reg, state_next;

    logic                      out_valid_reg, out_valid_next;
    logic [CH_W-1:0]           out_channel_reg, out_channel_next;
    logic signed [DATA_W-1:0]  out_position_reg, out_position_next;
    logic signed [DATA_W-1:0]  out_velocity_reg, out_velocity_next;

    logic [ALPHA_W-1:0]        alpha_reg, alpha_next;
    logic [GAIN_W-1:0]         position_gain_reg, position_gain_next;
    logic [GAIN_W-1:0]         velocity_gain_reg, velocity_gain_next;

    logic signed [DATA_W-1:0]  joint_pos_reg [NUM_JOINTS];
    logic signed [DATA_W-1:0]  joint_pos_next [NUM_JOINTS];
    logic signed [DATA_W-1:0]  joint_vel_reg [NUM_JOINTS];
    logic signed [DATA_W-1:0]  joint_vel_next [NUM_JOINTS];
    logic [DEG_W-1:0]          grip_target_prev_reg, grip_target_prev_next;
    logic [RAW_W-1:0]          grip_meas_prev_reg, grip_meas_prev_next;

    // working registers of the current transaction
    logic [CH_W-1:0]           ch_reg, ch_next;
    logic [RAW_W-1:0]          raw_reg, raw_next;
    logic signed [ADJ_W-1:0]   adj_reg, adj_next;
    logic signed [DATA_W-1:0]  old_pos_reg, old_pos_next;
    logic signed [DATA_W-1:0]  old_vel_reg, old_vel_next;
    logic signed [OP_A_W-1:0]  tmp_reg, tmp_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [DATA_W-1:0]  pos_reg, pos_next;
    logic signed [DATA_W-1:0]  vel_reg, vel_next;

    logic [ALPHA_W-1:0]        alpha_eff;
    logic [ALPHA_W-1:0]        alpha_comp;
    logic signed [OP_A_W-1:0]  op_a;
    logic signed [OP_B_W-1:0]  op_b;
    logic [DEG_W-1:0]          grip_deg;

    assign alpha_eff  = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign alpha_comp = ALPHA_ONE - alpha_eff;
    assign grip_deg   = grip_degrees(raw_reg);

    // shared multiplier operand select
    always_comb
    begin
        op_a = tmp_reg;
        op_b = '0;
        case (state_reg)
            S_ANG_MUL:
            begin
                op_a = OP_A_W'(adj_reg);
                op_b = ANGLE_SCALE;
            end
            S_P_MUL1, S_V_MUL1:
            begin
                op_b = OP_B_W'(alpha_eff);
            end
            S_P_MUL2:
            begin
                op_a = OP_A_W'(old_pos_reg);
                op_b = OP_B_W'(alpha_comp);
            end
            S_V_MUL2:
            begin
                op_a = OP_A_W'(old_vel_reg);
                op_b = OP_B_W'(alpha_comp);
            end
            S_POS_MUL:
            begin
                op_b = OP_B_W'(position_gain_reg);
            end
            S_DV_MUL:
            begin
                op_b = OP_B_W'(velocity_gain_reg);
            end
            default:
            begin
                op_b = '0;
            end
        endcase
    end

    assign prod_next = op_a * op_b;

    always_comb
    begin
        state_next            = state_reg;
        out_valid_next        = out_valid_reg && out_stall;
        out_channel_next      = out_channel_reg;
        out_position_next     = out_position_reg;
        out_velocity_next     = out_velocity_reg;
        alpha_next            = alpha_reg;
        position_gain_next    = position_gain_reg;
        velocity_gain_next    = velocity_gain_reg;
        joint_pos_next        = joint_pos_reg;
        joint_vel_next        = joint_vel_reg;
        grip_target_prev_next = grip_target_prev_reg;
        grip_meas_prev_next   = grip_meas_prev_reg;
        ch_next               = ch_reg;
        raw_next              = raw_reg;
        adj_next              = adj_reg;
        old_pos_next          = old_pos_reg;
        old_vel_next          = old_vel_reg;
        tmp_next              = tmp_reg;
        acc_next              = acc_reg;
        pos_next              = pos_reg;
        vel_next              = vel_reg;

        if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_ALPHA:         alpha_next         = cfg_data;
                CFG_POSITION_GAIN: position_gain_next = cfg_data[GAIN_W-1:0];
                CFG_VELOCITY_GAIN: velocity_gain_next = cfg_data[GAIN_W-1:0];
                default:           ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ch_next  = channel;
                    raw_next = raw_sample;
                    adj_next = joint_adjust(channel, raw_sample);
                    for (int j = 0; j < NUM_JOINTS; j++)
                    begin
                        if (channel == CH_W'(j))
                        begin
                            old_pos_next = joint_pos_reg[j];
                            old_vel_next = joint_vel_reg[j];
                        end
                    end
                    if (channel < JOINT_LIMIT)
                        state_next = S_ANG_MUL;
                    else if (channel >= GRIP_TARGET_CH)
                        state_next = S_GRIP;
                    else
                    begin
                        // joint channel not fitted
                        pos_next   = '0;
                        vel_next   = '0;
                        state_next = S_FINISH;
                    end
                end
            end
            S_ANG_MUL: state_next = S_ANG_RND;
            S_ANG_RND:
            begin
                tmp_next   = OP_A_W'(rnd16(ACC_W'(prod_reg)));
                state_next = S_P_MUL1;
            end
            S_P_MUL1: state_next = S_P_MUL2;
            S_P_MUL2:
            begin
                acc_next   = ACC_W'(prod_reg);
                state_next = S_P_SUM;
            end
            S_P_SUM:
            begin
                acc_next   = acc_reg + ACC_W'(prod_reg);
                state_next = S_P_RND;
            end
            S_P_RND:
            begin
                tmp_next   = OP_A_W'(rnd16(acc_reg));
                state_next = S_POS_MUL;
            end
            S_POS_MUL: state_next = S_POS_RND;
            S_POS_RND:
            begin
                pos_next   = sat24(rnd8(ACC_W'(prod_reg)));
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                tmp_next   = OP_A_W'(pos_reg) - OP_A_W'(old_pos_reg);
                state_next = S_DV_MUL;
            end
            S_DV_MUL: state_next = S_DV_RND;
            S_DV_RND:
            begin
                tmp_next   = OP_A_W'(sat24(rnd8(ACC_W'(prod_reg))));
                state_next = S_V_MUL1;
            end
            S_V_MUL1: state_next = S_V_MUL2;
            S_V_MUL2:
            begin
                acc_next   = ACC_W'(prod_reg);
                state_next = S_V_SUM;
            end
            S_V_SUM:
            begin
                acc_next   = acc_reg + ACC_W'(prod_reg);
                state_next = S_V_RND;
            end
            S_V_RND:
            begin
                vel_next   = sat24(rnd16(acc_reg));
                state_next = S_FINISH;
            end
            S_GRIP:
            begin
                if (ch_reg == GRIP_TARGET_CH)
                begin
                    pos_next = DATA_W'(grip_deg);
                    vel_next = DATA_W'(grip_deg) - DATA_W'(grip_target_prev_reg);
                end
                else
                begin
                    pos_next = DATA_W'(raw_reg);
                    vel_next = DATA_W'(raw_reg) - DATA_W'(grip_meas_prev_reg);
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // wait for the output register to free up, then commit
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    out_channel_next  = ch_reg;
                    out_position_next = pos_reg;
                    out_velocity_next = vel_reg;
                    for (int j = 0; j < NUM_JOINTS; j++)
                    begin
                        if (ch_reg == CH_W'(j))
                        begin
                            joint_pos_next[j] = pos_reg;
                            joint_vel_next[j] = vel_reg;
                        end
                    end
                    if (ch_reg == GRIP_TARGET_CH)
                        grip_target_prev_next = pos_reg[DEG_W-1:0];
                    if (ch_reg == GRIP_MEASURED_CH)
                        grip_meas_prev_next = pos_reg[RAW_W-1:0];
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            out_valid_reg        <= 1'b0;
            out_channel_reg      <= '0;
            out_position_reg     <= '0;
            out_velocity_reg     <= '0;
            alpha_reg            <= ALPHA_RESET;
            position_gain_reg    <= POSITION_GAIN_RESET;
            velocity_gain_reg    <= VELOCITY_GAIN_RESET;
            for (int j = 0; j < NUM_JOINTS; j++)
            begin
                joint_pos_reg[j] <= '0;
                joint_vel_reg[j] <= '0;
            end
            grip_target_prev_reg <= GRIP_RESET_DEG;
            grip_meas_prev_reg   <= GRIP_RESET_RAW;
        end
        else
        begin
            state_reg            <= state_next;
            out_valid_reg        <= out_valid_next;
            out_channel_reg      <= out_channel_next;
            out_position_reg     <= out_position_next;
            out_velocity_reg     <= out_velocity_next;
            alpha_reg            <= alpha_next;
            position_gain_reg    <= position_gain_next;
            velocity_gain_reg    <= velocity_gain_next;
            joint_pos_reg        <= joint_pos_next;
            joint_vel_reg        <= joint_vel_next;
            grip_target_prev_reg <= grip_target_prev_next;
            grip_meas_prev_reg   <= grip_meas_prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg      <= ch_next;
        raw_reg     <= raw_next;
        adj_reg     <= adj_next;
        old_pos_reg <= old_pos_next;
        old_vel_reg <= old_vel_next;
        tmp_reg     <= tmp_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        pos_reg     <= pos_next;
        vel_reg     <= vel_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign position    = out_position_reg;
    assign velocity    = out_velocity_reg;

    `JSEF_ASSERT_NEXT(a_accept_goes_busy, clk, rst_n, in_valid && !in_stall, in_stall,
        "accepted transaction did not start the sequencer")
    `JSEF_ASSERT_NEXT(a_finish_loads_output, clk, rst_n,
        state_reg == S_FINISH && (!out_valid_reg || !out_stall),
        out_valid_reg && state_reg == S_IDLE, "finished result not loaded into output")
    `JSEF_ASSERT_NOW(a_joint_path_channel, clk, rst_n, state_reg == S_ANG_MUL,
        ch_reg < JOINT_LIMIT, "filter sequence started for a non-joint channel")
    `JSEF_ASSERT_NOW(a_grip_target_range, clk, rst_n, 1'b1,
        grip_target_prev_reg <= 8'd180, "stored gripper target above 180 degrees")

endmodule

`default_nettype wire

// ===== verif/joint_sample_ema_filter_checker.sv =====
`default_nettype none

module joint_sample_ema_filter_checker
    import jsef_pkg::*;
#(
    parameter int NUM_JOINTS = DEF_NUM_JOINTS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]            cfg_data,

    input  wire logic                        in_valid,
    input  wire logic                        in_stall,
    input  wire logic [CH_W-1:0]             channel,
    input  wire logic [RAW_W-1:0]            raw_sample,

    input  wire logic                        out_valid,
    input  wire logic                        out_stall,
    input  wire logic [CH_W-1:0]             out_channel,
    input  wire logic signed [DATA_W-1:0]    position,
    input  wire logic signed [DATA_W-1:0]    velocity,

    output int                               mismatches,
    output int                               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [CH_W-1:0]          ch;
        logic signed [DATA_W-1:0] pos;
        logic signed [DATA_W-1:0] vel;
    } joint_result_t;

    // shadow of the block's state and registers
    logic signed [DATA_W-1:0] joint_pos [JOINT_CHANNELS];
    logic signed [DATA_W-1:0] joint_vel [JOINT_CHANNELS];
    logic [DEG_W-1:0]         target_prev;
    logic [RAW_W-1:0]         measured_prev;
    logic [ALPHA_W-1:0]       alpha;
    logic [GAIN_W-1:0]        position_gain;
    logic [GAIN_W-1:0]        velocity_gain;

    joint_result_t expected_results [$];

    function automatic longint round_half_away(longint x, int s);
        longint mag;
        mag = (x < 0) ? -x : x;
        mag = (mag + (longint'(1) << (s - 1))) >>> s;
        return (x < 0) ? -mag : mag;
    endfunction

    function automatic longint clamp_s24(longint x);
        if (x > S24_MAX)
            return S24_MAX;
        if (x < S24_MIN)
            return S24_MIN;
        return x;
    endfunction

    // computes the result of one sample and advances the shadow state
    function automatic joint_result_t filter_sample(logic [CH_W-1:0] ch,
                                                    logic [RAW_W-1:0] raw_in);
        joint_result_t r;
        longint raw, adj, angle, old_pos, p, pos, dv, vel, a, deg;
        raw = longint'(raw_in);
        a = (alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha);
        pos = 0;
        vel = 0;
        if (ch < JOINT_CHANNELS) begin
            if (ch < NUM_JOINTS) begin
                case (ch)
                    3'd0:    adj = raw - longint'(OFFSET_CENTER);
                    3'd1:    adj = longint'(OFFSET_SHOULDER) - raw;
                    3'd2:    adj = longint'(OFFSET_ELBOW) - raw;
                    3'd5:    adj = raw - longint'(OFFSET_CENTER);
                    default: adj = longint'(OFFSET_CENTER) - raw;
                endcase
                angle = round_half_away(adj * longint'(ANGLE_SCALE), 16);
                old_pos = longint'(joint_pos[ch]);
                p = round_half_away(a * angle + (longint'(ALPHA_ONE) - a) * old_pos, 16);
                pos = clamp_s24(round_half_away(p * longint'(position_gain), 8));
                dv = clamp_s24(round_half_away((pos - old_pos) * longint'(velocity_gain), 8));
                vel = clamp_s24(round_half_away(a * dv + (longint'(ALPHA_ONE) - a)
                                                * longint'(joint_vel[ch]), 16));
                joint_pos[ch] = pos[DATA_W-1:0];
                joint_vel[ch] = vel[DATA_W-1:0];
            end
        end else if (ch == GRIP_TARGET_CH) begin
            deg = raw * 180 / GRIP_FULL_SCALE;
            pos = deg;
            vel = deg - longint'(target_prev);
            target_prev = deg[DEG_W-1:0];
        end else begin
            pos = raw;
            vel = raw - longint'(measured_prev);
            measured_prev = raw_in;
        end
        r.ch = ch;
        r.pos = pos[DATA_W-1:0];
        r.vel = vel[DATA_W-1:0];
        return r;
    endfunction

    function automatic int field_differs(string name, logic signed [31:0] want,
                                         logic signed [31:0] got);
        if (want === got)
            return 0;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        joint_result_t want;
        if (!rst_n) begin
            for (int j = 0; j < JOINT_CHANNELS; j++) begin
                joint_pos[j] = '0;
                joint_vel[j] = '0;
            end
            target_prev = GRIP_RESET_DEG;
            measured_prev = GRIP_RESET_RAW;
            alpha = ALPHA_RESET;
            position_gain = POSITION_GAIN_RESET;
            velocity_gain = VELOCITY_GAIN_RESET;
            expected_results.delete();
            mismatches = 0;
        end else begin
            // retire the oldest transaction before queuing a new one
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, ch %0d position %0d velocity %0d",
                             $time, out_channel, position, velocity);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    mismatches += field_differs("out_channel", want.ch, out_channel)
                                + field_differs("position", want.pos, position)
                                + field_differs("velocity", want.vel, velocity);
                end
            end
            if (cfg_write_en) begin
                case (cfg_index)
                    CFG_ALPHA:         alpha = cfg_data[ALPHA_W-1:0];
                    CFG_POSITION_GAIN: position_gain = cfg_data[GAIN_W-1:0];
                    CFG_VELOCITY_GAIN: velocity_gain = cfg_data[GAIN_W-1:0];
                    default:           ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_results.insert(expected_results.size(),
                                        filter_sample(channel, raw_sample));
        end
        outstanding = expected_results.size();
    end

endmodule

`default_nettype wire

// ===== verif/joint_sample_ema_filter_test.sv =====
`default_nettype none

module joint_sample_ema_filter_test
    import jsef_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 3;
    localparam int SETTLE_CYCLES   = 24;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int NUM_DIRECTED    = 21;
    localparam int JOINTS          = DEF_NUM_JOINTS;

    // index past the last register; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]         cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [CH_W-1:0]          channel = '0;
    logic [RAW_W-1:0]         raw_sample = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [CH_W-1:0]          out_channel;
    logic signed [DATA_W-1:0] position;
    logic signed [DATA_W-1:0] velocity;

    int mismatches;
    int outstanding;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;

    // both ends of every joint offset, the zero-angle points of joints 0 to 2, gripper swings
    int directed_ch [NUM_DIRECTED] = '{0, 0, 0, 1, 1, 1, 2, 2, 2, 3, 3,
                                       4, 4, 5, 5, 6, 6, 6, 7, 7, 7};
    int directed_raw [NUM_DIRECTED] = '{0, 1023, 512, 0, 1023, 870, 0, 1023, 820, 0, 1023,
                                        1023, 0, 0, 1023, 1023, 0, 511, 1023, 0, 90};

    joint_sample_ema_filter #(
        .NUM_JOINTS(JOINTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .channel(channel),
        .raw_sample(raw_sample),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_channel(out_channel),
        .position(position),
        .velocity(velocity)
    );

    joint_sample_ema_filter_checker #(
        .NUM_JOINTS(JOINTS)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .channel(channel),
        .raw_sample(raw_sample),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_channel(out_channel),
        .position(position),
        .velocity(velocity),
        .mismatches(mismatches),
        .outstanding(outstanding)
    );

    always #CLK_HALF clk = ~clk;

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_sample(input logic [CH_W-1:0] ch, input logic [RAW_W-1:0] raw);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        channel <= ch;
        raw_sample <= raw;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    initial begin
        int unsigned alpha_val;
        int unsigned pgain;
        int unsigned vgain;
        idle_mode_t mode;
        logic [RAW_W-1:0] raw;
        int pick;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_sample(CH_W'(directed_ch[i]), RAW_W'(directed_raw[i]));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    alpha_val = ALPHA_ONE; pgain = 256; vgain = 256; mode = IDLE_NONE;
                end
                1: begin
                    alpha_val = 0; pgain = 65535; vgain = 65535; mode = IDLE_SENDER;
                end
                2: begin
                    // weight above one must behave as one; gains drive saturation
                    alpha_val = 131071; pgain = 65535; vgain = 65535; mode = IDLE_RECEIVER;
                end
                3: begin
                    alpha_val = $urandom_range(0, 65536); pgain = 0; vgain = 0;
                    mode = IDLE_BOTH;
                end
                4: begin
                    alpha_val = 1; pgain = 1; vgain = 1; mode = IDLE_NONE;
                end
                5: begin
                    alpha_val = ALPHA_RESET; pgain = POSITION_GAIN_RESET;
                    vgain = VELOCITY_GAIN_RESET;
                    mode = IDLE_SENDER;
                end
                default: begin
                    alpha_val = $urandom_range(0, 65536);
                    pgain = $urandom_range(0, 1023);
                    vgain = $urandom_range(0, 65535);
                    mode = (ph == 6) ? IDLE_RECEIVER : IDLE_BOTH;
                end
            endcase

            hold_until_drained();
            repeat (SETTLE_CYCLES) @(negedge clk);
            write_register(CFG_ALPHA, CFG_W'(alpha_val));
            write_register(CFG_POSITION_GAIN, CFG_W'(pgain));
            write_register(CFG_VELOCITY_GAIN, CFG_W'(vgain));
            write_register(CFG_UNUSED, CFG_W'($urandom_range(0, 131071)));

            case (mode)
                IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                IDLE_SENDER:   begin send_idle_pct = 65; recv_stall_pct = 0;  end
                IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default:       begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ((ph == 0 && n == 40) || $urandom_range(0, 59) == 0)
                    hold_until_drained();
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    raw = '0;
                else if (pick == 1)
                    raw = 10'd1023;
                else
                    raw = RAW_W'($urandom_range(0, 1023));
                send_sample(CH_W'($urandom_range(0, 7)), raw);
            end
        end

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
